// ===== sv/sli_pkg.sv =====
// Shared types and constants for the sorted literal intersection block.
// Used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package sli_pkg;

    localparam int LIT_W = 32;

    typedef logic signed [LIT_W-1:0] t_lit;

    // Request codes carried in req_type.
    typedef enum logic [1:0] {
        REQ_LOAD_FIRST  = 2'd0,
        REQ_LOAD_SECOND = 2'd1,
        REQ_RUN         = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MERGE,
        S_FINAL
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load_first;
        logic load_second;
        logic step;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic done;
        logic stall;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== sv/sli_in_if.sv =====
// Request channel: valid/ready handshake carrying req_type and literal.
// Depends on sli_pkg for the literal type.
`default_nettype none

interface sli_in_if;
    logic          valid;
    logic          ready;
    logic [1:0]    req_type;
    sli_pkg::t_lit literal;

    modport source (output valid, output req_type, output literal, input ready);
    modport sink   (input valid, input req_type, input literal, output ready);
endinterface

`default_nettype wire

// ===== sv/sli_out_if.sv =====
// Result channel: valid/ready handshake carrying one intersection result.
// Depends on sli_pkg for the literal type.
`default_nettype none

interface sli_out_if;
    logic          valid;
    logic          ready;
    logic          has_element;
    sli_pkg::t_lit common_literal;
    logic          last;
    logic          overflowed;

    modport source (output valid, output has_element, output common_literal,
                    output last, output overflowed, input ready);
    modport sink   (input valid, input has_element, input common_literal,
                    input last, input overflowed, output ready);
endinterface

`default_nettype wire

// ===== sv/sli_ctrl.sv =====
// Controller state machine for the intersection block: accepts requests,
// sequences the merge and the final result. Depends on sli_pkg.
`default_nettype none

module sli_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_req_type,
    output logic                   o_in_ready,
    input  wire sli_pkg::t_dp_stat i_stat,
    output sli_pkg::t_dp_cmd       o_cmd
);

    sli_pkg::t_state r_state;
    sli_pkg::t_state n_state;
    sli_pkg::t_req   req;

    assign req = sli_pkg::t_req'(i_req_type);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sli_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            sli_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (req)
                        sli_pkg::REQ_LOAD_FIRST:  o_cmd.load_first  = 1'b1;
                        sli_pkg::REQ_LOAD_SECOND: o_cmd.load_second = 1'b1;
                        sli_pkg::REQ_RUN:         n_state = sli_pkg::S_MERGE;
                        default:                  n_state = sli_pkg::S_IDLE;
                    endcase
                end
            end
            sli_pkg::S_MERGE: begin
                if (i_stat.done) begin
                    n_state = sli_pkg::S_FINAL;
                end else if (!i_stat.stall) begin
                    o_cmd.step = 1'b1;
                end
            end
            sli_pkg::S_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = sli_pkg::S_IDLE;
                end
            end
            default: n_state = sli_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/sli_datapath.sv =====
// Datapath for the intersection block: both list memories, counts, merge
// pointers, pending match and output register. Depends on sli_pkg.
`default_nettype none

module sli_datapath #(
    parameter int LIST_DEPTH = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sli_pkg::t_lit    i_literal,
    input  wire sli_pkg::t_dp_cmd i_cmd,
    output sli_pkg::t_dp_stat     o_stat,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_has_element,
    output sli_pkg::t_lit         o_common_literal,
    output logic                  o_last,
    output logic                  o_overflowed
);

    localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    function automatic logic [sli_pkg::LIT_W-1:0] mag(input sli_pkg::t_lit v);
        // Most negative value maps to 2^31 as an unsigned word.
        mag = v[sli_pkg::LIT_W-1] ? (~v + 1'b1) : v;
    endfunction

    sli_pkg::t_lit r_first_mem  [LIST_DEPTH];
    sli_pkg::t_lit r_second_mem [LIST_DEPTH];
    sli_pkg::t_lit r_a;
    sli_pkg::t_lit r_b;

    logic [CNT_W-1:0] r_first_cnt, r_second_cnt;
    logic [CNT_W-1:0] r_p, r_q, n_p, n_q;
    logic             r_ovf;
    logic             r_pend_valid;
    sli_pkg::t_lit    r_pend_lit;

    logic          r_out_valid;
    logic          r_out_has;
    sli_pkg::t_lit r_out_lit;
    logic          r_out_last;
    logic          r_out_ovf;

    logic less, equal, out_free, push_pend;

    assign less     = mag(r_a) < mag(r_b);
    assign equal    = (r_a == r_b);
    assign out_free = !r_out_valid || i_out_ready;

    assign o_stat.done     = (r_p >= r_first_cnt) || (r_q >= r_second_cnt);
    assign o_stat.stall    = !less && equal && r_pend_valid && !out_free;
    assign o_stat.out_free = out_free;

    // A new match pushes the previous one out; it is not the last.
    assign push_pend = i_cmd.step && !less && equal && r_pend_valid;

    always_comb begin
        n_p = r_p;
        n_q = r_q;
        if (i_cmd.finish) begin
            n_p = '0;
            n_q = '0;
        end else if (i_cmd.step) begin
            if (less) begin
                n_p = r_p + ONE_C;
            end else if (equal) begin
                n_p = r_p + ONE_C;
                n_q = r_q + ONE_C;
            end else begin
                n_q = r_q + ONE_C;
            end
        end
    end

    // Memories: one write port, one registered read port each.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_first && (r_first_cnt < DEPTH_C)) begin
            r_first_mem[r_first_cnt[ADDR_W-1:0]] <= i_literal;
        end
        if (i_cmd.load_second && (r_second_cnt < DEPTH_C)) begin
            r_second_mem[r_second_cnt[ADDR_W-1:0]] <= i_literal;
        end
        r_a <= r_first_mem[n_p[ADDR_W-1:0]];
        r_b <= r_second_mem[n_q[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_cnt  <= '0;
            r_second_cnt <= '0;
            r_ovf        <= 1'b0;
            r_p          <= '0;
            r_q          <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_p <= n_p;
            r_q <= n_q;
            if (i_cmd.load_first) begin
                if (r_first_cnt < DEPTH_C) begin
                    r_first_cnt <= r_first_cnt + ONE_C;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.load_second) begin
                if (r_second_cnt < DEPTH_C) begin
                    r_second_cnt <= r_second_cnt + ONE_C;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.step && !less && equal) begin
                r_pend_valid <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_first_cnt  <= '0;
                r_second_cnt <= '0;
                r_ovf        <= 1'b0;
                r_pend_valid <= 1'b0;
            end
            if (push_pend || i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && !less && equal) begin
            r_pend_lit <= r_a;
        end
        if (push_pend) begin
            r_out_has  <= 1'b1;
            r_out_lit  <= r_pend_lit;
            r_out_last <= 1'b0;
            r_out_ovf  <= r_ovf;
        end else if (i_cmd.finish) begin
            r_out_has  <= r_pend_valid;
            r_out_lit  <= r_pend_valid ? r_pend_lit : '0;
            r_out_last <= 1'b1;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_has_element    = r_out_has;
    assign o_common_literal = r_out_lit;
    assign o_last           = r_out_last;
    assign o_overflowed     = r_out_ovf;

endmodule

`default_nettype wire

// ===== sv/sorted_literal_intersection.sv =====
// Top level of the sorted literal intersection block.
// Depends on sli_pkg, sli_in_if, sli_out_if, sli_ctrl and sli_datapath.
`default_nettype none

// Two lists of signed literals, each loaded in ascending order of magnitude,
// are merged with two pointers and the literals common to both come out in
// merge order, the final one marked with last. A load into a full list is dropped
// and flags overflowed on every result of the next run. A run steps one pointer
// (or both on a match) per cycle unless a match waiting on the result side
// stalls it, since each list sits in a memory with a single registered read
// port. The merge ends once either pointer reaches its list's count, and the
// final result is pushed when the result side is free. An empty intersection
// gives a single result with has_element low. Both lists and the overflow flag
// are cleared when the run ends, and no request is taken while a run is under
// way. Request code 3 is ignored.
module sorted_literal_intersection #(
    parameter int LIST_DEPTH = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sli_in_if.sink     i_req,
    sli_out_if.source  o_res
);

    sli_pkg::t_dp_cmd  cmd;
    sli_pkg::t_dp_stat stat;

    // Sequence loads, merge steps and the closing result.
    sli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_req_type (i_req.req_type),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Hold the lists, walk them and register each result item.
    sli_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_literal        (i_req.literal),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_has_element    (o_res.has_element),
        .o_common_literal (o_res.common_literal),
        .o_last           (o_res.last),
        .o_overflowed     (o_res.overflowed)
    );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for sorted_literal_intersection: drives loads and runs over the request channel and
// checks every result against a merge predictor kept in the bench or a pinned expectation.
// Depends on sli_pkg, sli_in_if, sli_out_if and the block's RTL.
`default_nettype none

module tb;

    typedef sli_pkg::t_lit t_lit;

    localparam int CLK_PERIOD   = 12;
    localparam int LIST_DEPTH   = 64;
    localparam int N_ITEMS      = 380;
    localparam int N_DIR        = 25;
    localparam int HOLD_AT      = 12;    // result index at which the sink holds off
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 150;   // covers a full merge of two full lists

    // Request code 3 has no meaning; the block must ignore it.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic has_element;
        t_lit common_literal;
        logic last;
        logic overflowed;
    } t_result;

    // One row of the directed stimulus. When pinned is set, want is the result that the
    // row's run must give, read straight off the merge rules; otherwise the predictor decides.
    typedef struct packed {
        logic [1:0] req;
        t_lit       lit;
        logic       pinned;
        t_result    want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    sli_in_if  req_if ();
    sli_out_if res_if ();

    sorted_literal_intersection #(.LIST_DEPTH(LIST_DEPTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // Mirror of the block's two stores, their fill counts and the dropped-load flag.
    t_lit    first_store  [LIST_DEPTH];
    t_lit    second_store [LIST_DEPTH];
    int      first_fill;
    int      second_fill;
    logic    load_dropped;

    t_result expected_q [$];   // results still owed by the block, oldest first
    int      n_fail;
    int      n_items;          // loads and runs accepted; ignored codes do not count
    int      n_results;
    bit      no_idle;          // set for stretches where neither side pauses

    // Directed rows: empty run after reset, equal magnitude with opposite sign, the widest
    // positive literal, the most negative literal, an ignored code, zero, unordered stores
    // and a run with only the second list loaded.
    t_stim_row dir_rows [N_DIR] = '{
        '{sli_pkg::REQ_RUN,         32'sd0,         1'b1, '{1'b0, 32'sd0, 1'b1, 1'b0}},
        '{sli_pkg::REQ_LOAD_FIRST,  32'sd3,         1'b0, '0},
        '{sli_pkg::REQ_LOAD_FIRST,  -32'sd9,        1'b0, '0},
        '{sli_pkg::REQ_LOAD_FIRST,  32'sh7FFF_FFFF, 1'b0, '0},
        '{sli_pkg::REQ_LOAD_SECOND, -32'sd3,        1'b0, '0},
        '{sli_pkg::REQ_LOAD_SECOND, -32'sd9,        1'b0, '0},
        '{sli_pkg::REQ_LOAD_SECOND, 32'sh7FFF_FFFF, 1'b0, '0},
        '{sli_pkg::REQ_RUN,         32'sd0,         1'b0, '0},
        '{sli_pkg::REQ_LOAD_FIRST,  32'sh8000_0000, 1'b0, '0},
        '{sli_pkg::REQ_LOAD_SECOND, 32'sd7,         1'b0, '0},
        '{sli_pkg::REQ_LOAD_SECOND, 32'sh8000_0000, 1'b0, '0},
        '{REQ_UNUSED,               -32'sd1,        1'b0, '0},
        '{sli_pkg::REQ_RUN,         -32'sd1,        1'b1, '{1'b1, 32'sh8000_0000, 1'b1, 1'b0}},
        '{sli_pkg::REQ_LOAD_FIRST,  32'sd0,         1'b0, '0},
        '{sli_pkg::REQ_LOAD_SECOND, 32'sd1,         1'b0, '0},
        '{sli_pkg::REQ_RUN,         32'sd0,         1'b1, '{1'b0, 32'sd0, 1'b1, 1'b0}},
        '{sli_pkg::REQ_LOAD_FIRST,  32'sd0,         1'b0, '0},
        '{sli_pkg::REQ_LOAD_SECOND, 32'sd0,         1'b0, '0},
        '{sli_pkg::REQ_RUN,         32'sd0,         1'b1, '{1'b1, 32'sd0, 1'b1, 1'b0}},
        '{sli_pkg::REQ_LOAD_FIRST,  32'sd10,        1'b0, '0},
        '{sli_pkg::REQ_LOAD_FIRST,  32'sd2,         1'b0, '0},
        '{sli_pkg::REQ_LOAD_SECOND, 32'sd2,         1'b0, '0},
        '{sli_pkg::REQ_RUN,         32'sd0,         1'b0, '0},
        '{sli_pkg::REQ_LOAD_SECOND, 32'sd5,         1'b0, '0},
        '{sli_pkg::REQ_RUN,         32'sd0,         1'b1, '{1'b0, 32'sd0, 1'b1, 1'b0}}
    };

    // Apply one accepted request to the mirror and return the results it causes.
    function automatic void predict_merge(input logic [1:0] req, input t_lit lit,
                                          ref t_result out_q[$]);
        int          p;
        int          q;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        t_result     r;
        out_q.delete();
        case (req)
            sli_pkg::REQ_LOAD_FIRST: begin
                if (first_fill < LIST_DEPTH) begin
                    first_store[first_fill] = lit;
                    first_fill++;
                end else begin
                    load_dropped = 1'b1;
                end
            end
            sli_pkg::REQ_LOAD_SECOND: begin
                if (second_fill < LIST_DEPTH) begin
                    second_store[second_fill] = lit;
                    second_fill++;
                end else begin
                    load_dropped = 1'b1;
                end
            end
            sli_pkg::REQ_RUN: begin
                p = 0;
                q = 0;
                while (p < first_fill && q < second_fill) begin
                    a = first_store[p];
                    b = second_store[q];
                    // Magnitude as unsigned: the most negative literal maps to 2^31.
                    mag_a = a[31] ? ~a + 32'd1 : a;
                    mag_b = b[31] ? ~b + 32'd1 : b;
                    if (mag_a < mag_b) begin
                        p++;
                    end else if (a == b) begin
                        r.has_element    = 1'b1;
                        r.common_literal = a;
                        r.last           = 1'b0;
                        r.overflowed     = load_dropped;
                        out_q.insert(out_q.size(), r);
                        p++;
                        q++;
                    end else begin
                        q++;
                    end
                end
                if (out_q.size() == 0) begin
                    r.has_element    = 1'b0;
                    r.common_literal = '0;
                    r.last           = 1'b1;
                    r.overflowed     = load_dropped;
                    out_q.insert(out_q.size(), r);
                end else begin
                    out_q[out_q.size()-1].last = 1'b1;
                end
                first_fill   = 0;
                second_fill  = 0;
                load_dropped = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // Offer one item, hold it until the block takes it, then queue what it must produce.
    // Entered and left at a falling edge; valid stays high when the next item follows at once.
    task automatic offer_item(input t_stim_row row);
        int      gap;
        t_result owed_q [$];
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid    = 1'b1;
        req_if.req_type = row.req;
        req_if.literal  = row.lit;
        do @(posedge i_clk); while (!req_if.ready);
        predict_merge(row.req, row.lit, owed_q);
        if (row.pinned) begin
            expected_q.insert(expected_q.size(), row.want);
        end else begin
            foreach (owed_q[i]) expected_q.insert(expected_q.size(), owed_q[i]);
        end
        if (row.req != REQ_UNUSED) n_items++;
        @(negedge i_clk);
    endtask

    // Build two lists, load them in a random interleave and finish with a run.
    // Sorted lists step up in magnitude and share some literals, some with flipped sign;
    // unsorted lists are raw random words. Spill loads go past the store depth.
    task automatic send_list_pair(input int n_cand, input bit sorted, input bit wide,
                                  input bit all_common, input int n_spill);
        t_lit        first_q  [$];
        t_lit        second_q [$];
        int unsigned mag;
        t_lit        lit;
        int          pick;
        t_stim_row   row;
        t_stim_row   junk;
        row  = '0;
        junk = '0;
        if (sorted) begin
            mag = wide ? $urandom_range(0, 32'h3FFF_FFFF) : $urandom_range(0, 16);
            for (int i = 0; i < n_cand; i++) begin
                lit  = $urandom_range(0, 1) ? -t_lit'(mag) : t_lit'(mag);
                pick = all_common ? 2 : $urandom_range(0, 5);
                case (pick)
                    0: first_q.insert(first_q.size(), lit);
                    1: second_q.insert(second_q.size(), lit);
                    4: begin
                        first_q.insert(first_q.size(), lit);
                        second_q.insert(second_q.size(), -lit);
                    end
                    default: begin
                        first_q.insert(first_q.size(), lit);
                        second_q.insert(second_q.size(), lit);
                    end
                endcase
                // A zero step puts equal magnitudes side by side in one list.
                mag += wide ? $urandom_range(1, 32'h00FF_FFFF) : $urandom_range(0, 4);
            end
            // Close some wide lists with the most negative literal, the largest magnitude.
            if (wide && $urandom_range(0, 3) == 0) begin
                first_q.insert(first_q.size(), 32'sh8000_0000);
                second_q.insert(second_q.size(), 32'sh8000_0000);
            end
        end else begin
            for (int i = 0; i < n_cand; i++) first_q.insert(first_q.size(), t_lit'($urandom()));
            for (int i = 0; i < n_cand; i++) begin
                if ($urandom_range(0, 1) == 0)
                    second_q.insert(second_q.size(),
                                    first_q[$urandom_range(0, first_q.size() - 1)]);
                else
                    second_q.insert(second_q.size(), t_lit'($urandom()));
            end
        end
        for (int i = 0; i < n_spill; i++) begin
            first_q.insert(first_q.size(), t_lit'($urandom()));
            second_q.insert(second_q.size(), t_lit'($urandom()));
        end

        while (first_q.size() != 0 || second_q.size() != 0) begin
            if (second_q.size() == 0 || (first_q.size() != 0 && $urandom_range(0, 1) == 0))
            begin
                row.req = sli_pkg::REQ_LOAD_FIRST;
                row.lit = first_q.pop_front();
            end else begin
                row.req = sli_pkg::REQ_LOAD_SECOND;
                row.lit = second_q.pop_front();
            end
            // Slip in an ignored code now and then; it must leave the lists untouched.
            if ($urandom_range(0, 15) == 0) begin
                junk.req = REQ_UNUSED;
                junk.lit = t_lit'($urandom());
                offer_item(junk);
            end
            offer_item(row);
        end
        row.req = sli_pkg::REQ_RUN;
        row.lit = t_lit'($urandom());
        offer_item(row);
    endtask

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Stimulus: reset, directed rows, then random list pairs until the item budget is spent.
    initial begin
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.req_type = sli_pkg::REQ_LOAD_FIRST;
        req_if.literal  = '0;
        first_fill      = 0;
        second_fill     = 0;
        load_dropped    = 1'b0;
        n_fail          = 0;
        n_items         = 0;
        no_idle         = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) offer_item(dir_rows[i]);

        // Open with two full lists that match everywhere and spill over: the longest run,
        // every result flagged overflowed. The sink's long hold-off lands inside it.
        send_list_pair(LIST_DEPTH, 1'b1, 1'b1, 1'b1, 2);

        while (n_items < N_ITEMS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 8)
                send_list_pair($urandom_range(0, 10), 1'b1, $urandom_range(0, 1), 1'b0, 0);
            else
                send_list_pair($urandom_range(1, 8), 1'b0, 1'b0, 1'b0, 0);
        end
        req_if.valid = 1'b0;

        // Drain: wait for every owed result, then give stray results time to show up.
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Result sink: pause at random, hold off once for a long stretch so the block backs up
    // into the request side, and check each taken result against the oldest expectation.
    initial begin
        int      stall;
        t_result want;
        res_if.ready = 1'b0;
        n_results    = 0;
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (n_results == HOLD_AT) stall = HOLD_CYCLES;
            if (stall != 0) begin
                res_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_if.ready = 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            n_results++;
            if (expected_q.size() == 0) begin
                $error("result with none expected: common_literal %0d", res_if.common_literal);
                n_fail++;
            end else begin
                want = expected_q.pop_front();
                if (res_if.has_element !== want.has_element) begin
                    $error("has_element: expected %0d, got %0d",
                           want.has_element, res_if.has_element);
                    n_fail++;
                end
                if (res_if.common_literal !== want.common_literal) begin
                    $error("common_literal: expected %0d, got %0d",
                           want.common_literal, res_if.common_literal);
                    n_fail++;
                end
                if (res_if.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, res_if.last);
                    n_fail++;
                end
                if (res_if.overflowed !== want.overflowed) begin
                    $error("overflowed: expected %0d, got %0d",
                           want.overflowed, res_if.overflowed);
                    n_fail++;
                end
            end
            @(negedge i_clk);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(CLK_PERIOD * 200000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/sli_pkg.sv
sv/sli_in_if.sv
sv/sli_out_if.sv
sv/sli_ctrl.sv
sv/sli_datapath.sv
sv/sorted_literal_intersection.sv
verif/tb.sv
